>>> hdl/sobel_edge_magnitude_threshold_defines.svh
// Assertion macros for the Sobel edge magnitude block.
// Expects aclk and aresetn in the scope of each use; no other dependencies.
`ifndef SOBEL_EDGE_MAGNITUDE_THRESHOLD_DEFINES_SVH
`define SOBEL_EDGE_MAGNITUDE_THRESHOLD_DEFINES_SVH

// expr must never hold at a clock edge outside reset
`define SEMT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) \
        else $error(msg);

// cons must hold in the cycle after ante
`define SEMT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/semt_pkg.sv
// Shared constants, types and helper functions for the Sobel edge magnitude block.
// No dependencies.
package semt_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int PIXEL_BITS = 8;

    // configuration port
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_THRESHOLD = CFG_IDX_W'(2);
    localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
    localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);
    localparam logic [CFG_W-1:0] THRESH_RESET = CFG_W'(0);

    // input kinds
    localparam logic FUNC_FLUSH = 1'b1;

    // geometry
    localparam int WID_W      = $clog2(MAX_WIDTH + 1);
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int RING_AW    = $clog2(2 * MAX_WIDTH);
    localparam int RING_DEPTH = 2 ** RING_AW;

    // arithmetic widths
    localparam int ACC_W  = PIXEL_BITS + 2;
    localparam int GRAD_W = PIXEL_BITS + 3;
    localparam int SQ_W   = 2 * ACC_W;
    localparam int SUM_W  = SQ_W + 1;
    localparam int ROOT_W = (SUM_W + 1) / 2;
    localparam int TERM_W = 2 * ROOT_W + 1;
    localparam int MAG_W  = 11;
    localparam int MAG_MAX = 2047;

    // stream widths
    localparam int S_DATA_W = ((PIXEL_BITS + 7) / 8) * 8;
    localparam int M_DATA_W = ((MAG_W + 7) / 8) * 8;

    // result queue
    localparam int FIFO_DEPTH = 32;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_PW    = FIFO_AW + 1;

    // border flags and frame end, carried with each window position
    typedef struct packed {
        logic top_ok;
        logic bot_ok;
        logic left_ok;
        logic right_ok;
        logic last;
    } tag_t;

    function automatic logic [WID_W-1:0] clamp_width(input logic [CFG_W-1:0] v);
        logic [CFG_W+WID_W-1:0] wide;
        wide = (CFG_W + WID_W)'(v);
        if (v == '0) begin
            return WID_W'(1);
        end else if (wide > (CFG_W + WID_W)'(MAX_WIDTH)) begin
            return WID_W'(MAX_WIDTH);
        end else begin
            return WID_W'(v);
        end
    endfunction

    function automatic logic [CFG_W-1:0] clamp_height(input logic [CFG_W-1:0] v);
        return (v == '0) ? CFG_W'(1) : v;
    endfunction

    function automatic logic [MAG_W-1:0] sat_mag(input logic [ROOT_W-1:0] r);
        logic [ROOT_W+MAG_W-1:0] wide;
        wide = (ROOT_W + MAG_W)'(r);
        if (wide > (ROOT_W + MAG_W)'(MAG_MAX)) begin
            return MAG_W'(MAG_MAX);
        end else begin
            return MAG_W'(r);
        end
    endfunction

endpackage

>>> hdl/sobel_edge_magnitude_threshold.sv
// Streaming 3x3 Sobel gradient magnitude with threshold, one pixel per clock while s_tready is high.
// Depends on semt_pkg and sobel_edge_magnitude_threshold_defines.svh.
//
// Channel  Direction  Handshake            Payload
// s_       in         s_tvalid / s_tready  tdata: pixel_value; tuser: func
// m_       out        m_tvalid / m_tready  tdata: edge_magnitude; tlast: frame_last
// cfg_     in         cfg_we               cfg_addr: register index; cfg_wdata: value
//
// One item per clock while s_tready is high: the line store has one write and two
// read ports, so each request uses it once. The request that completes a window
// sends its result through ring read, window, gradient, squares, sum and 11 root
// stages into the output queue. Up to 32 results are queued; s_tready drops while
// 32 results are owed, and the pipeline itself never stalls. Reset initialises
// counters, valid bits, queue pointers and configuration; the line store is not
// cleared, as border masking hides every entry not written in the current frame.
`include "sobel_edge_magnitude_threshold_defines.svh"

module sobel_edge_magnitude_threshold
    import semt_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,    // [7:0] pixel_value
    input  logic [0:0]            s_tuser,    // [0] func

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,    // [10:0] edge_magnitude
    output logic                  m_tlast,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wdata
);

    localparam logic [1:0] ROWS_ONE  = 2'd1;
    localparam logic [1:0] ROWS_FULL = 2'd2;

    // ---------------- configuration and raster counters ----------------
    logic [WID_W-1:0]   w_eff_reg;
    logic [CFG_W-1:0]   h_eff_reg;
    logic [CFG_W-1:0]   thr_reg;
    logic [WID_W-1:0]   w_m1;
    logic [CFG_W-1:0]   h_m1;

    logic [COL_W-1:0]   in_col_reg, in_col_next;
    logic [1:0]         in_row_reg, in_row_next;    // saturates once two rows are in
    logic [COL_W-1:0]   out_col_reg, out_col_next;
    logic [CFG_W-1:0]   out_row_reg, out_row_next;
    logic [RING_AW-1:0] wp_reg;

    logic               s_accept;
    logic               emit_now;
    logic               last_now;
    logic               geom_write;
    tag_t               tag_now;
    logic [PIXEL_BITS-1:0] pix_in;

    assign w_m1 = w_eff_reg - WID_W'(1);
    assign h_m1 = h_eff_reg - CFG_W'(1);
    assign s_accept = s_tvalid && s_tready;
    assign pix_in = (s_tuser[0] == FUNC_FLUSH) ? '0 : s_tdata[PIXEL_BITS-1:0];

    // a result is due once one row plus one pixel has gone in
    assign emit_now = (in_row_reg == ROWS_FULL) ||
                      ((in_row_reg == ROWS_ONE) && (in_col_reg != '0));
    assign last_now = (out_row_reg == h_m1) && (WID_W'(out_col_reg) == w_m1);

    assign tag_now.top_ok   = (out_row_reg != '0);
    assign tag_now.bot_ok   = (out_row_reg != h_m1);
    assign tag_now.left_ok  = (out_col_reg != '0);
    assign tag_now.right_ok = (WID_W'(out_col_reg) != w_m1);
    assign tag_now.last     = last_now;

    assign geom_write = cfg_we &&
                        ((cfg_addr == REG_IMAGE_WIDTH) || (cfg_addr == REG_IMAGE_HEIGHT));

    always_comb begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (geom_write) begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end else if (s_accept) begin
            if (WID_W'(in_col_reg) == w_m1) begin
                in_col_next = '0;
                in_row_next = (in_row_reg == ROWS_FULL) ? ROWS_FULL : in_row_reg + 2'd1;
            end else begin
                in_col_next = in_col_reg + COL_W'(1);
            end
            if (emit_now) begin
                if (last_now) begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                end else if (WID_W'(out_col_reg) == w_m1) begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + CFG_W'(1);
                end else begin
                    out_col_next = out_col_reg + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_eff_reg   <= clamp_width(WIDTH_RESET);
            h_eff_reg   <= clamp_height(HEIGHT_RESET);
            thr_reg     <= THRESH_RESET;
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            wp_reg      <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_IMAGE_WIDTH:    w_eff_reg <= clamp_width(cfg_wdata);
                    REG_IMAGE_HEIGHT:   h_eff_reg <= clamp_height(cfg_wdata);
                    REG_EDGE_THRESHOLD: thr_reg   <= cfg_wdata;
                    default: ;
                endcase
            end
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            if (s_accept) begin
                wp_reg <= wp_reg + RING_AW'(1);
            end
        end
    end

    // ---------------- stage 1: line store ----------------
    // Ring of the last two rows; reads are read-first, which covers the case
    // where two rows span the whole ring.
    logic [PIXEL_BITS-1:0] line_mem [RING_DEPTH];
    logic [RING_AW-1:0]    ra_mid, ra_top;
    logic [PIXEL_BITS-1:0] mid_q, top_q;

    assign ra_mid = wp_reg - RING_AW'(w_eff_reg);
    assign ra_top = wp_reg - RING_AW'({w_eff_reg, 1'b0});

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            line_mem[wp_reg] <= pix_in;
            mid_q <= line_mem[ra_mid];
            top_q <= line_mem[ra_top];
        end
    end

    logic                  s1_valid_reg, s1_res_reg;
    logic [PIXEL_BITS-1:0] s1_pix_reg;
    tag_t                  s1_tag_reg;

    always_ff @(posedge aclk) begin
        s1_pix_reg <= pix_in;
        s1_tag_reg <= tag_now;
    end

    // ---------------- stage 2: 3x3 window ----------------
    logic [PIXEL_BITS-1:0] win_reg [3][3];     // [row][column], column 2 newest
    logic [PIXEL_BITS-1:0] new_col [3];
    logic                  s2_res_reg;
    tag_t                  s2_tag_reg;

    assign new_col[0] = top_q;
    assign new_col[1] = mid_q;
    assign new_col[2] = s1_pix_reg;

    always_ff @(posedge aclk) begin
        if (s1_valid_reg) begin
            for (int r = 0; r < 3; r++) begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= win_reg[r][2];
                win_reg[r][2] <= new_col[r];
            end
        end
        s2_tag_reg <= s1_tag_reg;
    end

    // ---------------- stage 3: gradients ----------------
    logic [PIXEL_BITS-1:0] pm [3][3];
    logic [2:0]            row_ok, col_ok;
    logic [ACC_W-1:0]      gx_pos, gx_neg, gy_pos, gy_neg;
    logic signed [GRAD_W-1:0] gx, gy;
    logic signed [GRAD_W-1:0] s3_gx_reg, s3_gy_reg;
    logic                  s3_res_reg, s3_last_reg;

    assign row_ok = {s2_tag_reg.bot_ok, 1'b1, s2_tag_reg.top_ok};
    assign col_ok = {s2_tag_reg.right_ok, 1'b1, s2_tag_reg.left_ok};

    // outside the image counts as zero
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                pm[r][c] = (row_ok[r] && col_ok[c]) ? win_reg[r][c] : '0;
            end
        end
    end

    assign gx_pos = ACC_W'(pm[0][2]) + (ACC_W'(pm[1][2]) << 1) + ACC_W'(pm[2][2]);
    assign gx_neg = ACC_W'(pm[0][0]) + (ACC_W'(pm[1][0]) << 1) + ACC_W'(pm[2][0]);
    assign gy_pos = ACC_W'(pm[2][0]) + (ACC_W'(pm[2][1]) << 1) + ACC_W'(pm[2][2]);
    assign gy_neg = ACC_W'(pm[0][0]) + (ACC_W'(pm[0][1]) << 1) + ACC_W'(pm[0][2]);
    assign gx = $signed({1'b0, gx_pos}) - $signed({1'b0, gx_neg});
    assign gy = $signed({1'b0, gy_pos}) - $signed({1'b0, gy_neg});

    always_ff @(posedge aclk) begin
        s3_gx_reg   <= gx;
        s3_gy_reg   <= gy;
        s3_last_reg <= s2_tag_reg.last;
    end

    // ---------------- stage 4: squares ----------------
    logic signed [2*GRAD_W-1:0] gx_sq, gy_sq;
    logic [SQ_W-1:0]            s4_sqx_reg, s4_sqy_reg;
    logic                       s4_res_reg, s4_last_reg;

    assign gx_sq = s3_gx_reg * s3_gx_reg;
    assign gy_sq = s3_gy_reg * s3_gy_reg;

    always_ff @(posedge aclk) begin
        s4_sqx_reg  <= gx_sq[SQ_W-1:0];
        s4_sqy_reg  <= gy_sq[SQ_W-1:0];
        s4_last_reg <= s3_last_reg;
    end

    // ---------------- stage 5: sum of squares ----------------
    logic [SUM_W-1:0] s5_sum_reg;
    logic             s5_res_reg, s5_last_reg;

    always_ff @(posedge aclk) begin
        s5_sum_reg  <= SUM_W'(s4_sqx_reg) + SUM_W'(s4_sqy_reg);
        s5_last_reg <= s4_last_reg;
    end

    // ---------------- root stages: one result bit each, MSB first ----------------
    logic [SUM_W-1:0]  sr_rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] sr_root_reg [ROOT_W];
    logic              sr_res_reg  [ROOT_W];
    logic              sr_last_reg [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_root
        localparam int B = ROOT_W - 1 - k;
        logic [SUM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic              res_in, last_in;
        logic [TERM_W-1:0] term;
        logic              take;

        if (k == 0) begin : g_first
            assign rem_in  = s5_sum_reg;
            assign root_in = '0;
            assign res_in  = s5_res_reg;
            assign last_in = s5_last_reg;
        end else begin : g_next
            assign rem_in  = sr_rem_reg[k-1];
            assign root_in = sr_root_reg[k-1];
            assign res_in  = sr_res_reg[k-1];
            assign last_in = sr_last_reg[k-1];
        end

        // (root + 2^B)^2 - root^2 = (2*root + 2^B) * 2^B
        assign term = ((TERM_W'(root_in) << 1) | (TERM_W'(1) << B)) << B;
        assign take = (TERM_W'(rem_in) >= term);

        always_ff @(posedge aclk) begin
            sr_rem_reg[k]  <= take ? SUM_W'(TERM_W'(rem_in) - term) : rem_in;
            sr_root_reg[k] <= take ? (root_in | (ROOT_W'(1) << B)) : root_in;
            sr_last_reg[k] <= last_in;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sr_res_reg[k] <= 1'b0;
            end else begin
                sr_res_reg[k] <= res_in;
            end
        end
    end

    // valid bits of the front stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s1_res_reg   <= 1'b0;
            s2_res_reg   <= 1'b0;
            s3_res_reg   <= 1'b0;
            s4_res_reg   <= 1'b0;
            s5_res_reg   <= 1'b0;
        end else begin
            s1_valid_reg <= s_accept;
            s1_res_reg   <= s_accept && emit_now;
            s2_res_reg   <= s1_res_reg;
            s3_res_reg   <= s2_res_reg;
            s4_res_reg   <= s3_res_reg;
            s5_res_reg   <= s4_res_reg;
        end
    end

    // ---------------- threshold and result queue ----------------
    logic [MAG_W-1:0]   mag_sat, mag_out;
    logic               fifo_wr, out_take, in_emit;
    logic [MAG_W-1:0]   fifo_mag  [FIFO_DEPTH];
    logic               fifo_last [FIFO_DEPTH];
    logic [FIFO_PW-1:0] wr_ptr_reg, rd_ptr_reg, fifo_count;
    logic [FIFO_PW-1:0] credit_reg;     // results owed: in flight plus queued

    assign mag_sat  = sat_mag(sr_root_reg[ROOT_W-1]);
    assign mag_out  = (CFG_W'(mag_sat) <= thr_reg) ? '0 : mag_sat;
    assign fifo_wr  = sr_res_reg[ROOT_W-1];
    assign out_take = m_tvalid && m_tready;
    assign in_emit  = s_accept && emit_now;

    assign fifo_count = wr_ptr_reg - rd_ptr_reg;
    assign m_tvalid   = (wr_ptr_reg != rd_ptr_reg);
    assign m_tdata    = M_DATA_W'(fifo_mag[rd_ptr_reg[FIFO_AW-1:0]]);
    assign m_tlast    = fifo_last[rd_ptr_reg[FIFO_AW-1:0]];
    assign s_tready   = (credit_reg < FIFO_PW'(FIFO_DEPTH));

    always_ff @(posedge aclk) begin
        if (fifo_wr) begin
            fifo_mag[wr_ptr_reg[FIFO_AW-1:0]]  <= mag_out;
            fifo_last[wr_ptr_reg[FIFO_AW-1:0]] <= sr_last_reg[ROOT_W-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            credit_reg <= '0;
        end else begin
            if (fifo_wr) begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_PW'(1);
            end
            if (out_take) begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_PW'(1);
            end
            credit_reg <= credit_reg + FIFO_PW'(in_emit) - FIFO_PW'(out_take);
        end
    end

    // ---------------- assertions ----------------
    logic counts_clear;

    assign counts_clear = (in_col_reg == '0) && (in_row_reg == '0) &&
                          (out_col_reg == '0) && (out_row_reg == '0);

    `SEMT_NEVER(a_queue_overflow, fifo_wr && (fifo_count == FIFO_PW'(FIFO_DEPTH)), "queue overflow")
    `SEMT_NEVER(a_credit_cover, credit_reg < fifo_count, "queued results exceed results owed")
    `SEMT_NEXT(a_frame_restart, in_emit && last_now, counts_clear, "frame did not restart")

endmodule

>>> tb/tb_sobel_edge_magnitude_threshold.sv
`timescale 1ns / 100ps
// Self-checking testbench for sobel_edge_magnitude_threshold.
// Depends on semt_pkg and the block's RTL; predicts every edge magnitude from
// its own window model and checks the result stream under random idling.
module tb_sobel_edge_magnitude_threshold;
    import semt_pkg::*;

    localparam logic FUNC_PIXEL     = 1'b0;
    localparam int   STORE_DEPTH    = 2 * MAX_WIDTH + 4;
    localparam int   DEFAULT_WIDTH  = 640;
    localparam int   DEFAULT_HEIGHT = 480;
    localparam int   DEFAULT_THRESH = 0;
    localparam int   DRAIN_CYCLES   = 48;
    localparam int   HOLD_CYCLES    = 350;
    localparam int   RANDOM_ITEMS   = 1050;
    localparam int   MAX_REPORTS    = 10;

    typedef struct {
        logic [MAG_W-1:0] mag;
        logic             last;
    } edge_t;

    // Raster model of the block: pixel history, position and owed magnitudes
    class edge_map_tracker;
        logic [CFG_W-1:0] width_reg;
        logic [CFG_W-1:0] height_reg;
        logic [CFG_W-1:0] thresh_reg;
        bit [7:0]         pixels[STORE_DEPTH];
        int unsigned      col;
        int unsigned      row;
        int unsigned      emitted;
        edge_t            owed[$];
        int unsigned      failures;
        int unsigned      checked;

        function new();
            width_reg  = CFG_W'(DEFAULT_WIDTH);
            height_reg = CFG_W'(DEFAULT_HEIGHT);
            thresh_reg = CFG_W'(DEFAULT_THRESH);
            failures   = 0;
            checked    = 0;
            restart();
        endfunction

        function void restart();
            col     = 0;
            row     = 0;
            emitted = 0;
        endfunction

        function int unsigned eff_width();
            if (width_reg == 0) return 1;
            if (width_reg > MAX_WIDTH) return MAX_WIDTH;
            return 32'(width_reg);
        endfunction

        function int unsigned eff_height();
            return (height_reg == 0) ? 1 : 32'(height_reg);
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                REG_IMAGE_WIDTH: begin
                    width_reg = val;
                    restart();
                end
                REG_IMAGE_HEIGHT: begin
                    height_reg = val;
                    restart();
                end
                REG_EDGE_THRESHOLD: begin
                    thresh_reg = val;
                end
                default: begin
                end
            endcase
        endfunction

        // bit-by-bit floor square root, 12 result bits cover 8-bit pixels
        function int unsigned root(int unsigned v);
            int unsigned r;
            int unsigned t;
            r = 0;
            for (int b = 11; b >= 0; b--) begin
                t = r | (32'd1 << b);
                if (t * t <= v) r = t;
            end
            return r;
        endfunction

        function void take_pixel(logic func, logic [7:0] pix);
            int unsigned w, h, pos, r, c, mag;
            int          gx, gy, rr, cc, px;
            edge_t       e;
            w   = eff_width();
            h   = eff_height();
            pos = row * w + col;
            pixels[pos % STORE_DEPTH] = (func == FUNC_FLUSH) ? 8'd0 : pix;
            col++;
            if (col >= w) begin
                col = 0;
                row++;
            end
            // window of the oldest owed pixel completes one row plus one pixel later
            if (pos < w + 1) return;
            r  = emitted / w;
            c  = emitted % w;
            gx = 0;
            gy = 0;
            for (int dr = -1; dr <= 1; dr++) begin
                for (int dc = -1; dc <= 1; dc++) begin
                    rr = int'(r) + dr;
                    cc = int'(c) + dc;
                    if (rr >= 0 && rr < int'(h) && cc >= 0 && cc < int'(w)) begin
                        px = 32'(pixels[(rr * w + cc) % STORE_DEPTH]);
                        gx += px * dc * ((dr == 0) ? 2 : 1);
                        gy += px * dr * ((dc == 0) ? 2 : 1);
                    end
                end
            end
            mag = root(gx * gx + gy * gy);
            if (mag > MAG_MAX) mag = MAG_MAX;
            if (mag <= thresh_reg) mag = 0;
            e.mag  = MAG_W'(mag);
            e.last = (emitted == w * h - 1);
            emitted++;
            if (e.last) restart();
            owed.push_back(e);
        endfunction

        function void check_edge(logic [MAG_W-1:0] mag, logic last);
            edge_t e;
            checked++;
            if (owed.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("%0t: unexpected edge %0d last %0b", $time, mag, last);
                return;
            end
            e = owed.pop_front();
            if (mag !== e.mag || last !== e.last) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("%0t: edge %0d last %0b, expected edge %0d last %0b",
                             $time, mag, last, e.mag, e.last);
            end
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata;
    logic [0:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_DATA_W-1:0]  m_tdata;
    logic                 m_tlast;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_addr;
    logic [CFG_W-1:0]     cfg_wdata;

    edge_map_tracker tracker;
    bit              steady;
    int unsigned     sent;

    sobel_edge_magnitude_threshold dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #40_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            tracker.check_edge(m_tdata[MAG_W-1:0], m_tlast);
    end

    // result side: spells of eager and of stalling acceptance, two long hold-offs
    initial begin
        int  stall, holds, spell;
        bit  eager;
        m_tready = 1'b0;
        stall    = 0;
        holds    = 0;
        spell    = 0;
        eager    = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (holds < 2 && s_tvalid && tracker.checked >= 150 + holds * 300) begin
                m_tready <= 1'b0;
                holds++;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            if (spell == 0) begin
                eager = ($urandom_range(0, 3) == 0);
                spell = $urandom_range(50, 400);
            end
            spell--;
            if (eager) begin
                m_tready <= 1'b1;
            end else if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 2) == 0) stall = idle_len();
            end
        end
    end

    task automatic send_item(input logic func, input logic [7:0] pix);
        int gap;
        gap = steady ? 0 : idle_len();
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_W'(pix);
        s_tuser  <= func;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        tracker.take_pixel(func, pix);
        sent++;
    endtask

    // n raster requests in one of several textures, with the odd flush mixed in
    task automatic send_raster(input int n, input int style);
        logic [7:0] level, pix;
        int         v;
        level = 8'($urandom);
        for (int i = 0; i < n; i++) begin
            case (style)
                0:       pix = 8'($urandom);
                1:       pix = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
                2:       pix = level;
                default: begin
                    v   = int'(level) + int'($urandom_range(0, 6)) - 3;
                    pix = (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : 8'(v);
                end
            endcase
            if ($urandom_range(0, 19) == 0)
                send_item(FUNC_FLUSH, 8'($urandom));
            else
                send_item(FUNC_PIXEL, pix);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        tracker.set_reg(idx, val);
    endtask

    // wait out owed results and the pipeline depth of result-free requests
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (tracker.owed.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin
        int unsigned w, h, frames, style, start;
        int          r;
        tracker   = new();
        steady    = 1'b0;
        sent      = 0;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = FUNC_PIXEL;
        cfg_we    = 1'b0;
        cfg_addr  = REG_IMAGE_WIDTH;
        cfg_wdata = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // default geometry after reset: only the first few results come out
        send_raster(645, 0);
        drain();

        write_reg(REG_IMAGE_WIDTH, 11'd3);
        write_reg(REG_IMAGE_HEIGHT, 11'd3);
        write_reg(REG_EDGE_THRESHOLD, 11'd0);
        send_item(FUNC_PIXEL, 8'hFF);
        send_item(FUNC_PIXEL, 8'h00);
        send_item(FUNC_PIXEL, 8'hFF);
        send_item(FUNC_FLUSH, 8'hA5);   // inside the frame: counts as a zero pixel
        send_item(FUNC_PIXEL, 8'hFF);
        send_item(FUNC_PIXEL, 8'h01);
        send_item(FUNC_PIXEL, 8'h80);
        send_item(FUNC_PIXEL, 8'hFF);
        send_item(FUNC_PIXEL, 8'h7F);
        send_item(FUNC_FLUSH, 8'h00);
        send_item(FUNC_FLUSH, 8'hFF);
        send_item(FUNC_PIXEL, 8'hFF);   // past the frame: drains like a flush
        send_item(FUNC_PIXEL, 8'h55);
        drain();

        // zero width and height fall back to a single pixel
        write_reg(REG_IMAGE_WIDTH, 11'd0);
        write_reg(REG_IMAGE_HEIGHT, 11'd0);
        send_item(FUNC_PIXEL, 8'hC3);
        send_item(FUNC_FLUSH, 8'h00);
        send_item(FUNC_FLUSH, 8'h3C);
        drain();

        // top threshold masks every magnitude
        write_reg(REG_IMAGE_WIDTH, 11'd2);
        write_reg(REG_IMAGE_HEIGHT, 11'd2);
        write_reg(REG_EDGE_THRESHOLD, 11'd2047);
        send_item(FUNC_PIXEL, 8'hFF);
        send_item(FUNC_PIXEL, 8'h00);
        send_item(FUNC_PIXEL, 8'h00);
        send_item(FUNC_PIXEL, 8'hFF);
        send_item(FUNC_FLUSH, 8'h00);
        send_item(FUNC_FLUSH, 8'h00);
        send_item(FUNC_FLUSH, 8'h00);
        drain();

        start = sent;
        while (sent - start < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 8)       write_reg(REG_IMAGE_WIDTH, 11'd0);
            else if (r < 18) write_reg(REG_IMAGE_WIDTH, 11'd1);
            else if (r < 22) write_reg(REG_IMAGE_WIDTH, 11'd2047);
            else             write_reg(REG_IMAGE_WIDTH, CFG_W'($urandom_range(2, 10)));
            r = $urandom_range(0, 99);
            if (r < 8)       write_reg(REG_IMAGE_HEIGHT, 11'd0);
            else if (r < 18) write_reg(REG_IMAGE_HEIGHT, 11'd1);
            else if (r < 24) write_reg(REG_IMAGE_HEIGHT, 11'd2047);
            else             write_reg(REG_IMAGE_HEIGHT, CFG_W'($urandom_range(2, 8)));
            r = $urandom_range(0, 99);
            if (r < 20)      write_reg(REG_EDGE_THRESHOLD, 11'd0);
            else if (r < 28) write_reg(REG_EDGE_THRESHOLD, 11'd2047);
            else if (r < 55) write_reg(REG_EDGE_THRESHOLD, CFG_W'($urandom_range(1, 300)));
            else if (r < 75) write_reg(REG_EDGE_THRESHOLD, CFG_W'($urandom_range(0, 2047)));
            steady = ($urandom_range(0, 2) == 0);
            w      = tracker.eff_width();
            h      = tracker.eff_height();
            frames = $urandom_range(1, 3);
            for (int f = 0; f < frames; f++) begin
                style = $urandom_range(0, 3);
                if (w * h > 300) begin
                    send_raster($urandom_range(1, 200), style);
                    break;
                end
                if ($urandom_range(0, 9) == 0) begin
                    // frame cut short; the next geometry write restarts it
                    send_raster($urandom_range(1, w * h), style);
                    break;
                end
                send_raster(w * h, style);
                for (int i = 0; i <= int'(w); i++) begin
                    if ($urandom_range(0, 4) == 0)
                        send_item(FUNC_PIXEL, 8'($urandom));
                    else
                        send_item(FUNC_FLUSH, 8'($urandom));
                end
            end
            drain();
        end

        if (tracker.failures == 0 && tracker.owed.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+hdl
hdl/semt_pkg.sv
hdl/sobel_edge_magnitude_threshold.sv
tb/tb_sobel_edge_magnitude_threshold.sv
